FILE: hdl/stm_pkg.sv
package stm_pkg;

  // Datapath widths
  localparam int unsigned ElevW  = 20;
  localparam int unsigned CordW  = 44;  // CORDIC x/y, holds mag << 8 with gain
  localparam int unsigned AngW   = 33;  // CORDIC angle accumulator, Q2.30 signed
  localparam int unsigned GradW  = 31;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 24;

  localparam logic [14:0] HALF_PI_Q14 = 15'd25736;
  localparam logic [GradW-1:0] GRAD_CAP = {GradW{1'b1}};

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_LINE_LENGTH     = 3'd0,
    REG_LINE_COUNT      = 3'd1,
    REG_INV_RESOLUTION  = 3'd2,
    REG_SLOPE_LOWER     = 3'd3,
    REG_SLOPE_CRITICAL  = 3'd4,
    REG_INV_SLOPE_RANGE = 3'd5
  } cfg_reg_e;

  // Register reset values
  localparam logic [10:0] RST_LINE_LENGTH     = 11'd1024;
  localparam logic [15:0] RST_LINE_COUNT      = 16'd1024;
  localparam logic [15:0] RST_INV_RESOLUTION  = 16'd5120;
  localparam logic [14:0] RST_SLOPE_LOWER     = 15'd4289;
  localparam logic [14:0] RST_SLOPE_CRITICAL  = 15'd10008;
  localparam logic [23:0] RST_INV_SLOPE_RANGE = 24'd1165000;

  typedef struct packed {
    logic signed [ElevW-1:0] elevation;
    logic                    height_ok;
    logic                    padding;
  } stm_in_t;

  typedef struct packed {
    logic [14:0] slope_angle;
    logic        slope_ok;
    logic [15:0] traversability;
    logic        score_ok;
    logic        last_cell;
  } stm_out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [CfgDatW-1:0] data;
  } stm_cfg_t;

  // atan(2^-i) in Q2.30
  function automatic logic [30:0] atan_q30(input logic [4:0] i);
    logic [30:0] r;
    case (i)
      5'd0:  r = 31'd843314857;
      5'd1:  r = 31'd497837829;
      5'd2:  r = 31'd263043837;
      5'd3:  r = 31'd133525159;
      5'd4:  r = 31'd67021687;
      5'd5:  r = 31'd33543516;
      5'd6:  r = 31'd16775851;
      5'd7:  r = 31'd8388437;
      5'd8:  r = 31'd4194283;
      5'd9:  r = 31'd2097149;
      5'd10: r = 31'd1048576;
      5'd11: r = 31'd524288;
      5'd12: r = 31'd262144;
      5'd13: r = 31'd131072;
      5'd14: r = 31'd65536;
      5'd15: r = 31'd32768;
      5'd16: r = 31'd16384;
      5'd17: r = 31'd8192;
      5'd18: r = 31'd4096;
      5'd19: r = 31'd2048;
      5'd20: r = 31'd1024;
      5'd21: r = 31'd512;
      5'd22: r = 31'd256;
      5'd23: r = 31'd128;
      default: r = 31'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/stm_if.sv
// Input cell channel
interface stm_in_if;
  logic             valid;
  logic             ready;
  stm_pkg::stm_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Result channel
interface stm_out_if;
  logic              valid;
  logic              ready;
  stm_pkg::stm_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Register write channel
interface stm_cfg_if;
  logic              valid;
  logic              ready;
  stm_pkg::stm_cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/stm_sqrt.sv
// Floor square root, one root bit per cycle
module stm_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] radicand_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [63:0] rad_q, rad_d;
  logic [33:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [33:0] rem_sh, trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    rem_sh = {rem_q[31:0], rad_q[63:62]};
    trial  = {root_q, 2'b01};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      // restoring step on the next bit pair
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[30:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[30:0], 1'b0};
      end
      rad_d = {rad_q[61:0], 2'b00};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: hdl/stm_cordic_cell.sv
// One CORDIC vectoring micro-rotation, registered
module stm_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                                  clk_i,
  input  logic signed [stm_pkg::CordW-1:0]      x_i,
  input  logic signed [stm_pkg::CordW-1:0]      y_i,
  input  logic signed [stm_pkg::AngW-1:0]       z_i,
  output logic signed [stm_pkg::CordW-1:0]      x_o,
  output logic signed [stm_pkg::AngW-1:0]       z_o,
  output logic signed [stm_pkg::CordW-1:0]      y_o
);

  logic signed [stm_pkg::CordW-1:0] xs, ys;
  logic signed [stm_pkg::AngW-1:0]  ang;

  assign xs  = x_i >>> STEP;
  assign ys  = y_i >>> STEP;
  assign ang = $signed({2'b00, stm_pkg::atan_q30(5'(STEP))});

  // rotate toward y = 0
  always_ff @(posedge clk_i) begin
    if (!y_i[stm_pkg::CordW-1]) begin
      x_o <= x_i + ys;
      y_o <= y_i - xs;
      z_o <= z_i + ang;
    end else begin
      x_o <= x_i - ys;
      y_o <= y_i + xs;
      z_o <= z_i - ang;
    end
  end

endmodule

FILE: hdl/slope_traversability_map_core.sv
// Channel   Dir  Payload                                        Handshake
// in_i      in   elevation, height_ok, padding                  valid/ready
// out_o     out  slope_angle, slope_ok, traversability,         valid/ready
//                score_ok, last_cell
// cfg_i     in   index, data                                    valid/ready
//
// One item at a time: a cell that finishes a cell of the previous line goes
// through four line-store reads, 32 square root iterations, one pass down
// the CORDIC cell chain and a score multiply.
// Items of line 0 and stray padding are taken without leaving the idle state.
// rst_ni clears control state and the configuration registers; the line store is not cleared.
// A result waiting in the output register holds the sequencer in its last
// step only when a newer result is ready to be written.
module slope_traversability_map_core #(
  parameter int unsigned MAX_LINE     = 1024,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stm_in_if.sink    in_i,
  stm_out_if.source out_o,
  stm_cfg_if.sink   cfg_i
);

  localparam int unsigned AW = $clog2(MAX_LINE);
  localparam int unsigned MW = $clog2(2 * MAX_LINE);
  localparam int unsigned LW = $clog2(MAX_LINE + 1);
  localparam int unsigned CNW = $clog2(CORDIC_STEPS + 1);
  localparam int unsigned CW = stm_pkg::CordW;
  localparam int unsigned ZW = stm_pkg::AngW;

  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_RC   = 15'b000000000000010,
    S_RL   = 15'b000000000000100,
    S_RR   = 15'b000000000001000,
    S_RT   = 15'b000000000010000,
    S_WR   = 15'b000000000100000,
    S_GRAD = 15'b000000001000000,
    S_MULG = 15'b000000010000000,
    S_SQX  = 15'b000000100000000,
    S_SQY  = 15'b000001000000000,
    S_SQRT = 15'b000010000000000,
    S_CORD = 15'b000100000000000,
    S_ANG  = 15'b001000000000000,
    S_MULS = 15'b010000000000000,
    S_OUT  = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [10:0] line_length_q;
  logic [15:0] line_count_q;
  logic [15:0] inv_res_q;
  logic [14:0] slope_lower_q;
  logic [14:0] slope_crit_q;
  logic [23:0] inv_range_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_length_q <= stm_pkg::RST_LINE_LENGTH;
      line_count_q  <= stm_pkg::RST_LINE_COUNT;
      inv_res_q     <= stm_pkg::RST_INV_RESOLUTION;
      slope_lower_q <= stm_pkg::RST_SLOPE_LOWER;
      slope_crit_q  <= stm_pkg::RST_SLOPE_CRITICAL;
      inv_range_q   <= stm_pkg::RST_INV_SLOPE_RANGE;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        stm_pkg::REG_LINE_LENGTH:     line_length_q <= cfg_i.data.data[10:0];
        stm_pkg::REG_LINE_COUNT:      line_count_q  <= cfg_i.data.data[15:0];
        stm_pkg::REG_INV_RESOLUTION:  inv_res_q     <= cfg_i.data.data[15:0];
        stm_pkg::REG_SLOPE_LOWER:     slope_lower_q <= cfg_i.data.data[14:0];
        stm_pkg::REG_SLOPE_CRITICAL:  slope_crit_q  <= cfg_i.data.data[14:0];
        stm_pkg::REG_INV_SLOPE_RANGE: inv_range_q   <= cfg_i.data.data;
        default: ;
      endcase
    end
  end

  // Raster position and its derived flags
  logic [AW-1:0] axis_q, axis_d;
  logic [15:0]   line_q, line_d;
  logic [LW-1:0] len;
  logic [15:0]   cnt;
  logic [AW:0]   ax_p1;
  logic          drain, last, l_ex, r_ex, t_ex;

  always_comb begin
    if (line_length_q == 11'd0) len = LW'(1);
    else if (32'(line_length_q) > MAX_LINE) len = LW'(MAX_LINE);
    else len = LW'(line_length_q);
  end

  assign cnt   = (line_count_q == 16'd0) ? 16'd1 : line_count_q;
  assign drain = line_q >= cnt;
  assign ax_p1 = {1'b0, axis_q} + {{AW{1'b0}}, 1'b1};
  assign last  = 32'(ax_p1) >= 32'(len);
  assign r_ex  = !last;
  assign l_ex  = axis_q != '0;
  assign t_ex  = line_q >= 16'd2;

  // position after the current item
  always_comb begin
    axis_d = AW'(ax_p1);
    line_d = line_q;
    if (last) begin
      axis_d = '0;
      line_d = drain ? 16'd0 : line_q + 16'd1;
    end
  end

  // Line store: two banks of MAX_LINE cells, bit 20 valid
  logic [20:0]   mem [2 * MAX_LINE];
  logic [MW-1:0] raddr, waddr;
  logic [20:0]   rd_q, wdata;
  logic          we;
  logic [MW-1:0] cbase, wbase;

  assign wbase = line_q[0] ? MW'(MAX_LINE) : '0;
  assign cbase = line_q[0] ? '0 : MW'(MAX_LINE);

  always_comb begin
    case (state_q)
      S_RL:    raddr = cbase + MW'(l_ex ? axis_q - AW'(1) : axis_q);
      S_RR:    raddr = cbase + MW'(r_ex ? AW'(ax_p1) : axis_q);
      S_RT:    raddr = wbase + MW'(axis_q);
      default: raddr = cbase + MW'(axis_q);
    endcase
  end

  assign waddr = wbase + MW'(axis_q);

  always_ff @(posedge clk_i) begin
    rd_q <= mem[raddr];
    if (we) mem[waddr] <= wdata;
  end

  // Accepted item and neighbor words
  stm_pkg::stm_in_t in_q;
  logic [20:0] cw_q, lw_q, rw_q, tw_q, bw;
  logic        accept, skip;

  assign in_i.ready = state_q == S_IDLE;
  assign accept     = in_i.valid && in_i.ready;
  assign skip       = in_i.data.padding && !drain;

  always_comb begin
    we    = 1'b0;
    wdata = {in_q.height_ok, in_q.elevation};
    if (accept && !skip && line_q == 16'd0) begin
      we    = 1'b1;
      wdata = {in_i.data.height_ok, in_i.data.elevation};
    end else if (state_q == S_WR && !drain) begin
      we = 1'b1;
    end
  end

  assign bw = drain ? 21'd0 : {in_q.height_ok, in_q.elevation};

  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_i.data;
    if (state_q == S_RL) cw_q <= rd_q;
    if (state_q == S_RR) lw_q <= rd_q;
    if (state_q == S_RT) rw_q <= rd_q;
    if (state_q == S_WR) tw_q <= rd_q;
  end

  // Axis difference: central, one-sided doubled, or none
  function automatic logic signed [22:0] axis_diff(input logic lo_ok,
                                                   input logic [20:0] lo,
                                                   input logic hi_ok,
                                                   input logic [20:0] hi,
                                                   input logic [20:0] c);
    logic signed [22:0] l, h, m, d;
    l = 23'(signed'(lo[19:0]));
    h = 23'(signed'(hi[19:0]));
    m = 23'(signed'(c[19:0]));
    if (lo_ok && hi_ok) d = h - l;
    else if (hi_ok) d = (h - m) <<< 1;
    else if (lo_ok) d = (m - l) <<< 1;
    else d = '0;
    return d;
  endfunction

  logic signed [22:0] dx, dy;
  logic               lox, hix, loy, hiy;
  logic [21:0]        dmx_q, dmy_q;
  logic               ok_q;

  assign lox = l_ex && lw_q[20];
  assign hix = r_ex && rw_q[20];
  assign loy = t_ex && tw_q[20];
  assign hiy = bw[20];
  assign dx  = axis_diff(lox, lw_q, hix, rw_q, cw_q);
  assign dy  = axis_diff(loy, tw_q, hiy, bw, cw_q);

  // Gradient magnitudes, squares and root
  logic [37:0]               mx, my;
  logic [stm_pkg::GradW-1:0] gx_q, gy_q;
  logic [61:0]               sqx_q;
  logic [63:0]               radicand;
  logic                      sq_done;
  logic [31:0]               root;
  logic                      mag_zero_q;

  assign mx = 38'(dmx_q) * 38'(inv_res_q);
  assign my = 38'(dmy_q) * 38'(inv_res_q);
  assign radicand = 64'(sqx_q) + 64'(62'(gy_q) * 62'(gy_q));

  always_ff @(posedge clk_i) begin
    if (state_q == S_GRAD) begin
      dmx_q <= 22'(dx[22] ? -dx : dx);
      dmy_q <= 22'(dy[22] ? -dy : dy);
      ok_q  <= cw_q[20] && (lox || hix || loy || hiy);
    end
    if (state_q == S_MULG) begin
      gx_q <= (mx > 38'(stm_pkg::GRAD_CAP)) ? stm_pkg::GRAD_CAP : mx[30:0];
      gy_q <= (my > 38'(stm_pkg::GRAD_CAP)) ? stm_pkg::GRAD_CAP : my[30:0];
    end
    if (state_q == S_SQX) sqx_q <= 62'(gx_q) * 62'(gx_q);
  end

  stm_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_SQY),
    .radicand_i (radicand),
    .done_o     (sq_done),
    .root_o     (root)
  );

  // CORDIC chain fed from held registers
  logic signed [CW-1:0] x_c [CORDIC_STEPS + 1];
  logic signed [CW-1:0] y_c [CORDIC_STEPS + 1];
  logic signed [ZW-1:0] z_c [CORDIC_STEPS + 1];
  logic signed [CW-1:0] y_feed_q;
  logic [CNW-1:0]       cord_cnt_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_SQRT && sq_done) begin
      y_feed_q   <= $signed({{(CW - 40){1'b0}}, root, 8'd0});
      mag_zero_q <= root == 32'd0;
    end
  end

  assign x_c[0] = $signed(CW'(1) <<< 25);
  assign y_c[0] = y_feed_q;
  assign z_c[0] = '0;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    stm_cordic_cell #(.STEP(k)) u_cell (
      .clk_i (clk_i),
      .x_i   (x_c[k]),
      .y_i   (y_c[k]),
      .z_i   (z_c[k]),
      .x_o   (x_c[k+1]),
      .z_o   (z_c[k+1]),
      .y_o   (y_c[k+1])
    );
  end

  // Angle rounding, score multiply
  logic signed [ZW-1:0] z_end;
  logic [ZW-1:0]        z_rnd;
  logic [16:0]          a_full;
  logic [14:0]          s_q;
  logic [39:0]          p_q;
  logic                 lt_q, gt_q;
  logic [24:0]          p_sh;
  logic [15:0]          score;

  assign z_end  = z_c[CORDIC_STEPS];
  assign z_rnd  = $unsigned(z_end) + ZW'(32768);
  assign a_full = z_rnd[32:16];
  assign p_sh   = p_q[39:15];

  always_ff @(posedge clk_i) begin
    if (state_q == S_ANG) begin
      if (!ok_q || mag_zero_q || z_end[ZW-1] || z_end == '0) s_q <= '0;
      else if (a_full > 17'(stm_pkg::HALF_PI_Q14)) s_q <= stm_pkg::HALF_PI_Q14;
      else s_q <= a_full[14:0];
    end
    if (state_q == S_MULS) begin
      p_q  <= 40'(15'(s_q - slope_lower_q)) * 40'(inv_range_q) + 40'd16384;
      lt_q <= s_q < slope_lower_q;
      gt_q <= s_q > slope_crit_q;
    end
  end

  always_comb begin
    if (lt_q) score = 16'd32768;
    else if (gt_q) score = 16'd0;
    else if (p_sh >= 25'd32768) score = 16'd0;
    else score = 16'd32768 - 16'(p_sh);
  end

  // Output register
  logic              ov_q;
  stm_pkg::stm_out_t out_q;
  logic              out_free, load;

  assign out_free = !ov_q || out_o.ready;
  assign load     = state_q == S_OUT && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (load) ov_q <= 1'b1;
    else if (out_o.ready) ov_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.slope_angle    <= s_q;
      out_q.slope_ok       <= ok_q;
      out_q.traversability <= ok_q ? score : 16'd0;
      out_q.score_ok       <= ok_q;
      out_q.last_cell      <= drain && last;
    end
  end

  assign out_o.valid = ov_q;
  assign out_o.data  = out_q;

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept && !skip && line_q != 16'd0) state_d = S_RC;
      S_RC:   state_d = S_RL;
      S_RL:   state_d = S_RR;
      S_RR:   state_d = S_RT;
      S_RT:   state_d = S_WR;
      S_WR:   state_d = S_GRAD;
      S_GRAD: state_d = S_MULG;
      S_MULG: state_d = S_SQX;
      S_SQX:  state_d = S_SQY;
      S_SQY:  state_d = S_SQRT;
      S_SQRT: if (sq_done) state_d = S_CORD;
      S_CORD: if (cord_cnt_q == CNW'(CORDIC_STEPS - 1)) state_d = S_ANG;
      S_ANG:  state_d = S_MULS;
      S_MULS: state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // position advances when a line-0 item is accepted, or once the item's result has been loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      axis_q     <= '0;
      line_q     <= '0;
      cord_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if ((accept && !skip && line_q == 16'd0) || load) begin
        axis_q <= axis_d;
        line_q <= line_d;
      end
      if (state_q == S_CORD) cord_cnt_q <= cord_cnt_q + CNW'(1);
      else cord_cnt_q <= '0;
    end
  end

  // Checks
  a_undef_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.data.slope_ok |->
      out_o.data.slope_angle == 15'd0 && out_o.data.traversability == 16'd0)
    else $error("undefined slope carries nonzero fields");

  a_score_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.data.traversability <= 16'd32768 &&
      out_o.data.slope_angle <= stm_pkg::HALF_PI_Q14)
    else $error("result out of range");

  a_ok_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.data.score_ok == out_o.data.slope_ok)
    else $error("score_ok differs from slope_ok");

  a_sqrt_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> state_q == S_SQRT)
    else $error("square root finished outside its step");

endmodule

FILE: dv/tb_slope_traversability_map_core.sv
`timescale 1ns / 100ps

module tb_slope_traversability_map_core;

  localparam int unsigned MaxLine   = 1024;
  localparam int unsigned Steps     = 16;
  localparam int unsigned Watchdog  = 20000;
  localparam int unsigned HoldOff   = 2000;
  localparam int unsigned ItemGoal  = 1700;
  localparam int unsigned SlopeMax  = 25736;

  // atan(2^-i), Q2.30
  localparam longint AtanTab [0:15] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768
  };

  logic clk_i;
  logic rst_ni;

  stm_in_if  cell_bus ();
  stm_out_if res_bus ();
  stm_cfg_if cfg_bus ();

  slope_traversability_map_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cell_bus),
    .out_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  // Clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow of registers and raster position
  logic [20:0] line_mem [0:2*MaxLine-1];
  logic [10:0] sh_len;
  logic [15:0] sh_cnt;
  logic [15:0] sh_inv_res;
  logic [14:0] sh_lower;
  logic [14:0] sh_crit;
  logic [23:0] sh_inv_range;
  int unsigned col_pos;
  int unsigned row_pos;

  stm_pkg::stm_out_t expected_q [$];
  int unsigned errors;
  int unsigned send_idle;
  int unsigned recv_stall;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  function automatic bit pct(input int unsigned p);
    return $urandom_range(99, 0) < p;
  endfunction

  function automatic longint elev_of(input logic [20:0] w);
    logic signed [19:0] e;
    e = w[19:0];
    return longint'(e);
  endfunction

  // |gradient| in 2^-17 units, saturated
  function automatic longint unsigned axis_grad(input bit lo_ok, input longint lo,
                                                input bit hi_ok, input longint hi,
                                                input longint c);
    longint d;
    longint unsigned m;
    if (lo_ok && hi_ok) d = hi - lo;
    else if (hi_ok) d = 2 * (hi - c);
    else if (lo_ok) d = 2 * (c - lo);
    else return 0;
    if (d < 0) d = -d;
    m = longint'(d) * longint'(sh_inv_res);
    return (m > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : m;
  endfunction

  // atan(sqrt(gx^2 + gy^2)) in Q2.14
  function automatic logic [14:0] slope_angle_of(input longint unsigned gx,
                                                 input longint unsigned gy);
    longint unsigned rem, root, bitv, a;
    longint x, y, z, xs, ys;
    rem  = gx * gx + gy * gy;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    if (root == 0) return 0;
    x = 64'sd1 <<< 25;
    y = longint'(root << 8);
    z = 0;
    for (int i = 0; i < Steps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + AtanTab[i];
      end else begin
        x = x - ys; y = y + xs; z = z - AtanTab[i];
      end
    end
    if (z <= 0) return 0;
    a = (longint'(z) + 32768) >> 16;
    return (a > SlopeMax) ? 15'(SlopeMax) : 15'(a);
  endfunction

  function automatic logic [15:0] score_of(input logic [14:0] s);
    longint unsigned p;
    if (s < sh_lower) return 16'd32768;
    if (s > sh_crit) return 16'd0;
    p = (longint'(s - sh_lower) * longint'(sh_inv_range) + 16384) >> 15;
    return (p >= 32768) ? 16'd0 : 16'(32768 - p);
  endfunction

  // Advance the raster by one accepted cell; returns 1 if a result is due
  function automatic bit predict_cell(input stm_pkg::stm_in_t it,
                                      output stm_pkg::stm_out_t r);
    int unsigned len, cnt, ax, ly, wbank, cbank;
    bit drain, last, okx, oky, ok, produced;
    logic [20:0] inw, cw, lw, rw, tw, bw;
    longint unsigned gx, gy;
    logic [14:0] s;
    len = (sh_len == 0) ? 1 : sh_len;
    cnt = (sh_cnt == 0) ? 1 : sh_cnt;
    if (len > MaxLine) len = MaxLine;
    drain = row_pos >= cnt;
    r = '0;
    if (it.padding && !drain) return 0;
    ax = col_pos % MaxLine;
    ly = row_pos;
    wbank = (ly & 1) * MaxLine;
    cbank = ((ly + 1) & 1) * MaxLine;
    inw = {it.height_ok, it.elevation};
    last = ax + 1 >= len;
    produced = 0;
    if (ly >= 1) begin
      cw = line_mem[cbank + ax];
      lw = (ax > 0) ? line_mem[cbank + ax - 1] : '0;
      rw = (ax + 1 < len) ? line_mem[cbank + ax + 1] : '0;
      tw = (ly >= 2) ? line_mem[wbank + ax] : '0;
      bw = drain ? '0 : inw;
      okx = lw[20] || rw[20];
      oky = tw[20] || bw[20];
      gx = axis_grad(lw[20], elev_of(lw), rw[20], elev_of(rw), elev_of(cw));
      gy = axis_grad(tw[20], elev_of(tw), bw[20], elev_of(bw), elev_of(cw));
      ok = cw[20] && (okx || oky);
      s = ok ? slope_angle_of(gx, gy) : '0;
      r.slope_angle    = s;
      r.slope_ok       = ok;
      r.traversability = ok ? score_of(s) : '0;
      r.score_ok       = ok;
      r.last_cell      = drain && last;
      produced = 1;
    end
    if (drain) begin
      if (last) begin
        col_pos = 0; row_pos = 0;
      end else begin
        col_pos = ax + 1;
      end
    end else begin
      line_mem[wbank + ax] = inw;
      if (last) begin
        col_pos = 0; row_pos = ly + 1;
      end else begin
        col_pos = ax + 1;
      end
    end
    return produced;
  endfunction

  // Offer one cell; expectation comes from the typed value when given
  task automatic send_cell(input stm_pkg::stm_in_t it, input bit typed,
                           input stm_pkg::stm_out_t typed_r);
    stm_pkg::stm_out_t r;
    while (pct(send_idle)) begin
      cell_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    cell_bus.valid <= 1'b1;
    cell_bus.data  <= it;
    do @(posedge clk_i); while (!cell_bus.ready);
    if (predict_cell(it, r)) expected_q.push_back(typed ? typed_r : r);
  endtask

  // Register write; valid is lowered by cfg_done
  task automatic write_reg(input stm_pkg::cfg_reg_e idx, input int unsigned val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= '{index: idx, data: stm_pkg::CfgDatW'(val)};
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      stm_pkg::REG_LINE_LENGTH:     sh_len       = 11'(val);
      stm_pkg::REG_LINE_COUNT:      sh_cnt       = 16'(val);
      stm_pkg::REG_INV_RESOLUTION:  sh_inv_res   = 16'(val);
      stm_pkg::REG_SLOPE_LOWER:     sh_lower     = 15'(val);
      stm_pkg::REG_SLOPE_CRITICAL:  sh_crit      = 15'(val);
      stm_pkg::REG_INV_SLOPE_RANGE: sh_inv_range = 24'(val);
      default: ;
    endcase
  endtask

  task automatic cfg_done();
    cfg_bus.valid <= 1'b0;
  endtask

  // Block must be idle before a register write
  task automatic wait_drained();
    cell_bus.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // Result checker and ready driver
  initial begin
    stm_pkg::stm_out_t want;
    res_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_bus.valid === 1'b1 && res_bus.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $time, res_bus.data);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (res_bus.data.slope_angle !== want.slope_angle ||
              res_bus.data.slope_ok !== want.slope_ok ||
              res_bus.data.traversability !== want.traversability ||
              res_bus.data.score_ok !== want.score_ok ||
              res_bus.data.last_cell !== want.last_cell) begin
            $display("%0t: result mismatch, expected %p, actual %p",
                     $time, want, res_bus.data);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= !pct(recv_stall);
      end
    end
  end

  // Watchdog: cycles with no item moving on any channel
  always @(posedge clk_i) begin
    if ((cell_bus.valid && cell_bus.ready) || (res_bus.valid === 1'b1 && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= Watchdog) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  typedef struct {
    bit                is_cfg;
    stm_pkg::cfg_reg_e idx;
    int unsigned       val;
    stm_pkg::stm_in_t  cell_in;
    bit                typed;
    stm_pkg::stm_out_t res;
  } stim_row_t;

  stim_row_t dir_rows [$];

  function automatic void add_cfg(input stm_pkg::cfg_reg_e idx, input int unsigned val);
    stim_row_t row;
    row = '{is_cfg: 1'b1, idx: idx, val: val, cell_in: '0, typed: 1'b0, res: '0};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cell(input int e, input bit ok, input bit pad,
                                   input bit typed, input stm_pkg::stm_out_t res);
    stim_row_t row;
    row = '{is_cfg: 1'b0, idx: stm_pkg::REG_LINE_LENGTH, val: 0,
            cell_in: '{elevation: 20'(e), height_ok: ok, padding: pad},
            typed: typed, res: res};
    dir_rows.push_back(row);
  endfunction

  // Random register set for one grid
  task automatic program_grid(input int unsigned phase);
    int unsigned len, cnt, ir, lo, cr, rg;
    len = (phase % 9 == 4) ? 0 : $urandom_range(12, 1);
    cnt = (phase % 11 == 5) ? 0 : $urandom_range(6, 1);
    if (phase == 1) begin len = 1; cnt = 20; end
    case ($urandom_range(9, 0))
      0: ir = 0;
      1: ir = 1;
      2: ir = 65535;
      default: ir = $urandom_range(8192, 256);
    endcase
    case ($urandom_range(9, 0))
      0: begin lo = 0; cr = SlopeMax; end
      1: begin lo = $urandom_range(SlopeMax, 1000); cr = $urandom_range(lo - 1, 0); end
      2: begin lo = SlopeMax; cr = SlopeMax; end
      default: begin
        lo = $urandom_range(12000, 0);
        cr = $urandom_range(SlopeMax, lo);
      end
    endcase
    case ($urandom_range(9, 0))
      0: rg = 0;
      1: rg = 24'hFFFFFF;
      default: rg = (cr > lo) ? ((32'd1 << 30) / (cr - lo)) : 24'hFFFFFF;
    endcase
    if (rg > 24'hFFFFFF) rg = 24'hFFFFFF;
    if (phase == 7) begin
      // A long line after the tallest count, then a single line to keep it short
      len = 700;
      write_reg(stm_pkg::REG_LINE_COUNT, 65535);
      cnt = 1;
    end
    write_reg(stm_pkg::REG_LINE_LENGTH, len);
    write_reg(stm_pkg::REG_LINE_COUNT, cnt);
    write_reg(stm_pkg::REG_INV_RESOLUTION, ir);
    write_reg(stm_pkg::REG_SLOPE_LOWER, lo);
    write_reg(stm_pkg::REG_SLOPE_CRITICAL, cr);
    write_reg(stm_pkg::REG_INV_SLOPE_RANGE, rg);
    cfg_done();
  endtask

  // One whole grid plus its drain, with stray padding mixed in
  task automatic run_grid(inout int unsigned sent);
    int unsigned len, cnt, k, noise;
    int mode, sx, sy, base;
    stm_pkg::stm_in_t it;
    len = (sh_len == 0) ? 1 : ((sh_len > MaxLine) ? MaxLine : sh_len);
    cnt = (sh_cnt == 0) ? 1 : sh_cnt;
    mode = $urandom_range(4, 0);
    case ($urandom_range(2, 0))
      0: k = 3;
      1: k = 15;
      default: k = 60;
    endcase
    noise = $urandom_range(3, 0);
    sx = $urandom_range(2 * k, 0) - int'(k);
    sy = $urandom_range(2 * k, 0) - int'(k);
    base = $urandom_range(400000, 0) - 200000;
    for (int y = 0; y < int'(cnt); y++) begin
      for (int x = 0; x < int'(len); x++) begin
        if (pct(4)) send_cell('{elevation: 20'($urandom), height_ok: $urandom,
                                padding: 1'b1}, 1'b0, '0);
        if (mode == 0) it.elevation = 20'($urandom);
        else it.elevation = 20'(base + x * sx + y * sy + $urandom_range(noise, 0));
        it.height_ok = !pct(8);
        it.padding   = 1'b0;
        send_cell(it, 1'b0, '0);
        sent++;
      end
    end
    // Drain the last line, mostly with padding
    for (int x = 0; x < int'(len); x++) begin
      it.elevation = 20'($urandom);
      it.height_ok = $urandom;
      it.padding   = !pct(20);
      send_cell(it, 1'b0, '0);
      sent++;
    end
  endtask

  // Main stimulus
  initial begin
    stm_pkg::stm_out_t flat, blank;
    int unsigned sent, phase;
    rst_ni         = 1'b0;
    cell_bus.valid = 1'b0;
    cell_bus.data  = '0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.data   = '0;
    errors = 0; hold_left = 0; quiet_cycles = 0;
    send_idle = 0; recv_stall = 0;
    foreach (line_mem[i]) line_mem[i] = '0;
    col_pos = 0; row_pos = 0;
    sh_len       = stm_pkg::RST_LINE_LENGTH;
    sh_cnt       = stm_pkg::RST_LINE_COUNT;
    sh_inv_res   = stm_pkg::RST_INV_RESOLUTION;
    sh_lower     = stm_pkg::RST_SLOPE_LOWER;
    sh_crit      = stm_pkg::RST_SLOPE_CRITICAL;
    sh_inv_range = stm_pkg::RST_INV_SLOPE_RANGE;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: 3x2 grid at reset thresholds, then a one-cell grid
    flat  = '{slope_angle: 0, slope_ok: 1, traversability: 32768, score_ok: 1,
              last_cell: 0};
    blank = '0;
    add_cfg(stm_pkg::REG_LINE_LENGTH, 3);
    add_cfg(stm_pkg::REG_LINE_COUNT, 2);
    add_cell(0, 1, 0, 0, blank);
    add_cell(0, 1, 0, 0, blank);
    add_cell(0, 1, 0, 0, blank);
    add_cell(0, 0, 1, 0, blank);          // stray padding, ignored
    add_cell(0, 1, 0, 1, flat);           // flat, bottom neighbour present
    add_cell(0, 0, 0, 1, flat);           // bottom missing, x still defined
    add_cell(524287, 1, 0, 0, blank);     // steep step, saturated gradient
    add_cell(0, 0, 1, 1, flat);           // drain: top only
    add_cell(-524288, 1, 0, 1, blank);    // drain item, invalid center
    add_cell(0, 0, 1, 0, blank);          // drain, last cell
    add_cfg(stm_pkg::REG_LINE_LENGTH, 0);
    add_cfg(stm_pkg::REG_LINE_COUNT, 0);
    add_cell(-524288, 1, 0, 0, blank);
    blank.last_cell = 1'b1;
    add_cell(0, 0, 1, 1, blank);          // drain, no neighbours at all: undefined slope
    add_cell(524287, 1, 1, 0, blank);     // stray padding, ignored
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        wait_drained();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
        cfg_done();
      end else begin
        send_cell(dir_rows[i].cell_in, dir_rows[i].typed, dir_rows[i].res);
      end
    end

    // Random grids, rotating through idle patterns
    sent  = 0;
    phase = 0;
    while (sent < ItemGoal) begin
      wait_drained();
      program_grid(phase);
      case (phase % 5)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 65; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 65; end
        3: begin send_idle = 17; recv_stall = 17; end
        default: begin
          send_idle = 0; recv_stall = 0;
          hold_left = HoldOff;
        end
      endcase
      run_grid(sent);
      phase++;
    end

    wait_drained();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/stm_pkg.sv
hdl/stm_if.sv
hdl/stm_sqrt.sv
hdl/stm_cordic_cell.sv
hdl/slope_traversability_map_core.sv
dv/tb_slope_traversability_map_core.sv
